FILE: rtl/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = IDX_W + 1;

    localparam logic [31:0] GRAIN_MASK  = 32'hFFFF_FF00;
    localparam logic [32:0] MAX_GRANT   = 33'h0_FFFF_FF00;
    localparam logic [31:0] RESET_POOL  = 32'd16777216;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic        is_free;
    } entry_t;

    typedef logic [ADDR_W-1:0] addr_t;

endpackage

FILE: rtl/ffpa_table.sv
// ----------------------------------------------------------------------------
// ffpa_table
// Two banks of block entries, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffpa_table (
    input  logic            aclk,
    input  logic            wr_en,
    input  ffpa_pkg::addr_t  wr_addr,
    input  ffpa_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  ffpa_pkg::addr_t  rd_addr,
    output ffpa_pkg::entry_t rd_data
);
    import ffpa_pkg::*;

    entry_t mem [2*MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/first_fit_pool_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator over a byte pool, with sort and coalesce on free.
// ----------------------------------------------------------------------------
// Channels: s_* carries one command transaction (tuser = command, tdata =
// request_size, free_offset); m_* returns one result transaction per command
// (tuser = status, tdata = granted_offset, granted_size). cfg_* writes the
// pool size and restarts the list as a single free block.
// One command is processed at a time; s_tready is high only when idle.
// Allocate: one table read per cycle over the list (n entries). Free: a
// search over the list, then a selection sort through the single table read
// port in n passes, each a full read of the list.
// The sorted list is written into the other table bank and the banks swap.
// Reset: the list restarts with a 16 MiB free block; the S_INIT state
// writes that entry into the table before s_tready and cfg_ready rise. The
// same initialization step follows every configuration write.
// A stalled receiver holds the result; the next command is accepted, but its
// result waits until the pending result transaction completes.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // request_size[31:0], free_offset[63:32]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // granted_offset[31:0], granted_size[63:32]
    output logic [1:0]  m_tuser,   // status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import ffpa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_SCAN, S_A_SPLIT, S_A_MARK, S_F_SCAN, S_F_MARK,
        S_SORT_SCAN, S_SORT_EMIT, S_SORT_FLUSH, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              bank_reg, bank_next;
    logic [31:0]       init_len_reg, init_len_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       offset_reg, offset_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_d_reg, rd_idx_d_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    entry_t            hit_reg, hit_next;
    entry_t            best_reg, best_next;
    logic              best_vld_reg, best_vld_next;
    entry_t            last_reg, last_next;
    logic [31:0]       prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    status_t           res_status_reg, res_status_next;
    logic [31:0]       res_off_reg, res_off_next;
    logic [31:0]       res_size_reg, res_size_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    status_t           m_tuser_reg, m_tuser_next;

    logic             wr_en, rd_en;
    addr_t            wr_addr, rd_addr;
    entry_t           wr_data, rd_data;
    logic [32:0]      want;
    logic             scan_end;
    logic [CNT_W-1:0] kept_m1;
    logic [32:0]      last_end;

    ffpa_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign want     = ({1'b0, s_tdata[31:0]} + 33'd255) & {1'b1, GRAIN_MASK};
    assign scan_end = (rd_idx_reg >= count_reg) && !rd_vld_reg;
    assign kept_m1  = kept_reg - CNT_W'(1);
    assign last_end = {1'b0, last_reg.start} + {1'b0, last_reg.length};

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        bank_next       = bank_reg;
        init_len_next   = init_len_reg;
        size_next       = size_reg;
        offset_next     = offset_reg;
        rd_idx_next     = rd_idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_d_next   = rd_idx_reg[IDX_W-1:0];
        hit_idx_next    = hit_idx_reg;
        hit_next        = hit_reg;
        best_next       = best_reg;
        best_vld_next   = best_vld_reg;
        last_next       = last_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        kept_next       = kept_reg;
        pass_next       = pass_reg;
        res_status_next = res_status_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        wr_en           = 1'b0;
        wr_addr         = {bank_reg, hit_idx_reg};
        wr_data         = hit_reg;
        rd_en           = 1'b0;
        rd_addr         = {bank_reg, rd_idx_reg[IDX_W-1:0]};

        if ((state_reg == S_A_SCAN || state_reg == S_F_SCAN || state_reg == S_SORT_SCAN)
            && rd_idx_reg < count_reg) begin
            rd_en       = 1'b1;
            rd_vld_next = 1'b1;
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        unique case (state_reg)
            S_INIT: begin
                wr_en      = 1'b1;
                wr_addr    = {bank_reg, IDX_W'(0)};
                wr_data    = '{start: 32'd0, length: init_len_reg, is_free: 1'b1};
                count_next = CNT_W'(1);
                state_next = S_IDLE;
            end
            S_IDLE: begin
                rd_idx_next     = '0;
                res_off_next    = '0;
                res_size_next   = '0;
                if (cfg_valid) begin
                    init_len_next = cfg_data & GRAIN_MASK;
                    state_next    = S_INIT;
                end else if (s_tvalid) begin
                    offset_next = s_tdata[63:32];
                    size_next   = want[31:0];
                    if (s_tuser == CMD_FREE) begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_F_SCAN;
                    end else begin
                        res_status_next = ST_NO_FIT;
                        state_next = (want == 33'd0 || want > MAX_GRANT) ? S_DONE : S_A_SCAN;
                    end
                end
            end
            S_A_SCAN: begin
                if (rd_vld_reg && rd_data.is_free && rd_data.length >= size_reg) begin
                    hit_idx_next = rd_idx_d_reg;
                    hit_next     = rd_data;
                    rd_vld_next  = 1'b0;
                    state_next   = S_A_SPLIT;
                end else if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_A_SPLIT: begin
                if (hit_reg.length > size_reg) begin
                    if (count_reg >= CNT_W'(MAX_ENTRIES)) begin
                        res_status_next = ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end else begin
                        wr_en      = 1'b1;
                        wr_addr    = {bank_reg, count_reg[IDX_W-1:0]};
                        wr_data    = '{start: hit_reg.start + size_reg,
                                       length: hit_reg.length - size_reg, is_free: 1'b1};
                        count_next = count_reg + CNT_W'(1);
                        state_next = S_A_MARK;
                    end
                end else begin
                    state_next = S_A_MARK;
                end
            end
            S_A_MARK: begin
                wr_en           = 1'b1;
                wr_data         = '{start: hit_reg.start, length: size_reg, is_free: 1'b0};
                res_status_next = ST_OK;
                res_off_next    = hit_reg.start;
                res_size_next   = size_reg;
                state_next      = S_DONE;
            end
            S_F_SCAN: begin
                if (rd_vld_reg && rd_data.start == offset_reg) begin
                    hit_idx_next = rd_idx_d_reg;
                    hit_next     = rd_data;
                    rd_vld_next  = 1'b0;
                    state_next   = S_F_MARK;
                end else if (scan_end) begin
                    state_next = S_DONE;
                end
            end
            S_F_MARK: begin
                wr_en           = 1'b1;
                wr_data         = '{start: hit_reg.start, length: hit_reg.length, is_free: 1'b1};
                res_status_next = ST_OK;
                rd_idx_next     = '0;
                best_vld_next   = 1'b0;
                have_prev_next  = 1'b0;
                kept_next       = '0;
                pass_next       = '0;
                state_next      = S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
                if (rd_vld_reg && (!have_prev_reg || rd_data.start > prev_reg)
                    && (!best_vld_reg || rd_data.start < best_reg.start)) begin
                    best_next     = rd_data;
                    best_vld_next = 1'b1;
                end
                if (scan_end) begin
                    state_next = S_SORT_EMIT;
                end
            end
            S_SORT_EMIT: begin
                prev_next      = best_reg.start;
                have_prev_next = 1'b1;
                if (kept_reg != '0 && last_reg.is_free && best_reg.is_free
                    && last_end == {1'b0, best_reg.start}) begin
                    last_next.length = last_reg.length + best_reg.length;
                end else begin
                    if (kept_reg != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = {!bank_reg, kept_m1[IDX_W-1:0]};
                        wr_data = last_reg;
                    end
                    last_next = best_reg;
                    kept_next = kept_reg + CNT_W'(1);
                end
                pass_next     = pass_reg + CNT_W'(1);
                rd_idx_next   = '0;
                best_vld_next = 1'b0;
                state_next    = (pass_reg + CNT_W'(1) == count_reg) ? S_SORT_FLUSH : S_SORT_SCAN;
            end
            S_SORT_FLUSH: begin
                wr_en      = 1'b1;
                wr_addr    = {!bank_reg, kept_m1[IDX_W-1:0]};
                wr_data    = last_reg;
                count_next = kept_reg;
                bank_next  = !bank_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_size_reg, res_off_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            count_reg     <= CNT_W'(1);
            bank_reg      <= 1'b0;
            init_len_reg  <= RESET_POOL;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bank_reg      <= bank_next;
            init_len_reg  <= init_len_next;
            rd_vld_reg    <= rd_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        size_reg       <= size_next;
        offset_reg     <= offset_next;
        rd_idx_reg     <= rd_idx_next;
        rd_idx_d_reg   <= rd_idx_d_next;
        hit_idx_reg    <= hit_idx_next;
        hit_reg        <= hit_next;
        best_reg       <= best_next;
        best_vld_reg   <= best_vld_next;
        last_reg       <= last_next;
        prev_reg       <= prev_next;
        have_prev_reg  <= have_prev_next;
        kept_reg       <= kept_next;
        pass_reg       <= pass_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count out of range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready && !cfg_ready)
        else $error("ready high while a command is in progress");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> (state_reg == S_INIT))
        else $error("configuration write did not restart the list");

    a_grant_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 64'd0))
        else $error("failed command carries a nonzero grant");
`endif

endmodule
